/* hdl/lkv_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module under hdl/.
package lkv_pkg;

    localparam int LKV_MAX_ENTRIES = 16;
    localparam int LKV_KEY_BITS    = 16;
    localparam int LKV_VALUE_BITS  = 16;

    localparam int           LKV_CAP_BITS  = 5;
    localparam logic [4:0]   LKV_CAP_RESET = 5'd16;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } lkv_cmd_t;

    // per-request status handed from the store to the result register
    typedef struct packed
    {
        logic hit;
        logic evicted;
    } lkv_flags_t;

endpackage

/* hdl/lkv_in_reg.sv */
// Request register: holds one accepted request until the store consumes it.
// Depends on lkv_pkg.
module lkv_in_reg
    import lkv_pkg::*;
#(
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [0:0]            cmd,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  advance,
    output logic                  pend_valid,
    output logic [0:0]            pend_cmd,
    output logic [KEY_BITS-1:0]   pend_key,
    output logic [VALUE_BITS-1:0] pend_value
);

    logic                  valid_reg;
    logic [0:0]            cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  load;

    assign req_ready = !valid_reg || advance;
    assign load      = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    assign pend_valid = valid_reg;
    assign pend_cmd   = cmd_reg;
    assign pend_key   = key_reg;
    assign pend_value = value_reg;

endmodule

/* hdl/lkv_store.sv */
// Fully associative entry store: parallel key compare, recency ranks,
// eviction and insert, all computed combinationally and committed on go. Depends on lkv_pkg.
module lkv_store
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = LKV_MAX_ENTRIES,
    parameter int KEY_BITS    = LKV_KEY_BITS,
    parameter int VALUE_BITS  = LKV_VALUE_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [LKV_CAP_BITS-1:0] cfg_wr_data,
    input  logic                    go,
    input  logic [0:0]              cmd,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [VALUE_BITS-1:0]   value,
    output lkv_flags_t              flags,
    output logic [VALUE_BITS-1:0]   read_value,
    output logic [KEY_BITS-1:0]     evicted_key
);

    localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = ((OCC_W > LKV_CAP_BITS) ? OCC_W : LKV_CAP_BITS) + 1;

    logic [KEY_BITS-1:0]     key_reg   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]   val_reg   [MAX_ENTRIES];
    logic [AGE_W-1:0]        age_reg   [MAX_ENTRIES];
    logic [AGE_W-1:0]        age_next  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  valid_reg;
    logic [MAX_ENTRIES-1:0]  valid_next;
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;
    logic [LKV_CAP_BITS-1:0] cap_reg;

    logic [MAX_ENTRIES-1:0]  match_vec;
    logic [MAX_ENTRIES-1:0]  evict_vec;
    logic [MAX_ENTRIES-1:0]  free_vec;
    logic [MAX_ENTRIES-1:0]  free_first;
    logic [MAX_ENTRIES-1:0]  write_vec;
    logic [AGE_W-1:0]        hit_age;
    logic [VALUE_BITS-1:0]   hit_val;
    logic [KEY_BITS-1:0]     ev_key;
    logic [CMP_W-1:0]        lim;
    logic [OCC_W-1:0]        occ_m1;
    logic                    hit_any;
    logic                    is_put;
    logic                    full;
    logic                    do_evict;
    logic                    do_insert;

    always_comb
    begin
        // effective capacity clamped to 1..MAX_ENTRIES
        priority if (cap_reg == '0)
            lim = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES))
            lim = CMP_W'(MAX_ENTRIES);
        else
            lim = CMP_W'(cap_reg);
    end

    assign is_put = (lkv_cmd_t'(cmd) == CMD_PUT);
    assign full   = CMP_W'(occ_reg) >= lim;
    assign occ_m1 = occ_reg - OCC_W'(1);

    always_comb
    begin
        hit_age = '0;
        hit_val = '0;
        ev_key  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == key);
            if (match_vec[i])
            begin
                hit_age = hit_age | age_reg[i];
                hit_val = hit_val | val_reg[i];
            end
        end
        hit_any  = |match_vec;
        do_evict = is_put && !hit_any && full;
        // oldest valid entry carries rank occupancy-1
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            evict_vec[i] = do_evict && valid_reg[i] && (OCC_W'(age_reg[i]) == occ_m1);
            if (evict_vec[i])
            begin
                ev_key = ev_key | key_reg[i];
            end
        end
        free_vec   = ~valid_reg | evict_vec;
        free_first = free_vec & (~free_vec + MAX_ENTRIES'(1));
        do_insert  = is_put && !hit_any && (|free_vec);
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        write_vec  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (hit_any)
        begin
            if (is_put)
            begin
                write_vec = match_vec;
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (match_vec[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && (age_reg[i] < hit_age))
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
        else if (do_insert)
        begin
            write_vec  = free_first;
            valid_next = (valid_reg & ~evict_vec) | free_first;
            if (!(|evict_vec))
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (free_first[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && !evict_vec[i])
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= LKV_CAP_RESET;
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            cap_reg   <= cfg_wr_data;
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (go && write_vec[i])
            begin
                val_reg[i] <= value;
                if (!hit_any)
                begin
                    key_reg[i] <= key;
                end
            end
        end
    end

    assign flags.hit     = hit_any;
    assign flags.evicted = |evict_vec;
    assign read_value    = (hit_any && !is_put) ? hit_val : '0;
    assign evicted_key   = ev_key;

    // keys are unique among valid entries
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("lkv_store: key present in more than one entry");

    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("lkv_store: occupancy out of step with valid entries");

    a_occ_limit: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= lim)
        else $error("lkv_store: occupancy above capacity");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (occ_reg == '0) && (valid_reg == '0))
        else $error("lkv_store: capacity write did not empty the store");

    a_put_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !cfg_wr_en && is_put) |=> (occ_reg != '0))
        else $error("lkv_store: store empty after a put");

endmodule

/* hdl/lkv_out_reg.sv */
// Result register: holds one response until the consumer takes it and
// decides when the pending request may advance. Depends on lkv_pkg.
module lkv_out_reg
    import lkv_pkg::*;
#(
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pend_valid,
    input  lkv_flags_t            flags,
    input  logic [VALUE_BITS-1:0] res_value,
    input  logic [KEY_BITS-1:0]   res_evicted_key,
    output logic                  advance,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] read_value,
    output logic                  evicted,
    output logic [KEY_BITS-1:0]   evicted_key
);

    logic                  valid_reg;
    lkv_flags_t            flags_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0]   ekey_reg;

    assign advance = pend_valid && (!valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flags_reg <= flags;
            value_reg <= res_value;
            ekey_reg  <= res_evicted_key;
        end
    end

    assign rsp_valid   = valid_reg;
    assign hit         = flags_reg.hit;
    assign evicted     = flags_reg.evicted;
    assign read_value  = value_reg;
    assign evicted_key = ekey_reg;

endmodule

/* hdl/lru_key_value_cache_top.sv */
// Top level of the LRU key-value cache: request register, entry store,
// result register. Depends on lkv_pkg, lkv_in_reg, lkv_store, lkv_out_reg.
//
//  channel   handshake              payload
//  request   req_valid / req_ready  cmd, key, value
//  response  rsp_valid / rsp_ready  hit, read_value, evicted, evicted_key
//  config    cfg_wr_en              cfg_wr_data (capacity)
//
// One request per cycle sustained while rsp_ready stays high; a request passes through the request register,
// then lookup and update into the result register.
// The whole compare/rank/update for a request fits between those registers.
// Reset and capacity writes clear all valid bits at once; no sweep.
// A stalled response holds the result register, which backs up the request
// register and then req_ready.
module lru_key_value_cache_top
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = LKV_MAX_ENTRIES,
    parameter int KEY_BITS    = LKV_KEY_BITS,
    parameter int VALUE_BITS  = LKV_VALUE_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [LKV_CAP_BITS-1:0] cfg_wr_data,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [0:0]              cmd,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [VALUE_BITS-1:0]   value,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    hit,
    output logic [VALUE_BITS-1:0]   read_value,
    output logic                    evicted,
    output logic [KEY_BITS-1:0]     evicted_key
);

    logic                  advance;
    logic                  pend_valid;
    logic [0:0]            pend_cmd;
    logic [KEY_BITS-1:0]   pend_key;
    logic [VALUE_BITS-1:0] pend_value;
    lkv_flags_t            flags;
    logic [VALUE_BITS-1:0] res_value;
    logic [KEY_BITS-1:0]   res_evicted_key;

    lkv_in_reg #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .cmd        (cmd),
        .key        (key),
        .value      (value),
        .advance    (advance),
        .pend_valid (pend_valid),
        .pend_cmd   (pend_cmd),
        .pend_key   (pend_key),
        .pend_value (pend_value)
    );

    lkv_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (advance),
        .cmd         (pend_cmd),
        .key         (pend_key),
        .value       (pend_value),
        .flags       (flags),
        .read_value  (res_value),
        .evicted_key (res_evicted_key)
    );

    lkv_out_reg #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_out_reg (
        .clk             (clk),
        .rst_n           (rst_n),
        .pend_valid      (pend_valid),
        .flags           (flags),
        .res_value       (res_value),
        .res_evicted_key (res_evicted_key),
        .advance         (advance),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .hit             (hit),
        .read_value      (read_value),
        .evicted         (evicted),
        .evicted_key     (evicted_key)
    );

endmodule

/* verif/lru_key_value_cache_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_top: directed and random get/put traffic,
// checked against an in-bench LRU predictor. Depends on lkv_pkg and the cache RTL.
module lru_key_value_cache_top_test;
    import lkv_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    typedef struct packed
    {
        lkv_cmd_t    op;
        logic [15:0] key;
        logic [15:0] value;
    } cache_req_t;

    typedef struct packed
    {
        logic        hit;
        logic [15:0] read_value;
        logic        evicted;
        logic [15:0] evicted_key;
    } cache_rsp_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    logic [0:0]  cmd         = CMD_GET;
    logic [15:0] key         = '0;
    logic [15:0] value       = '0;
    logic        rsp_valid;
    logic        rsp_ready   = 1'b0;
    logic        hit;
    logic [15:0] read_value;
    logic        evicted;
    logic [15:0] evicted_key;

    cache_req_t pending_requests[$];
    cache_rsp_t expected_responses[$];

    int idle_pct    = 0;
    int stall_pct   = 0;
    int error_count = 0;
    int cycle_count = 0;

    // predictor state
    logic [15:0] line_key   [LKV_MAX_ENTRIES];
    logic [15:0] line_value [LKV_MAX_ENTRIES];
    logic        line_valid [LKV_MAX_ENTRIES];
    int          line_age   [LKV_MAX_ENTRIES];
    int          fill_count;
    logic [4:0]  capacity_reg;

    lru_key_value_cache_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_store();
        for (int i = 0; i < LKV_MAX_ENTRIES; i++)
        begin
            line_valid[i] = 1'b0;
            line_age[i]   = 0;
        end
        fill_count = 0;
    endfunction

    function automatic int usable_entries();
        if (capacity_reg < 1)
            return 1;
        if (capacity_reg > LKV_MAX_ENTRIES)
            return LKV_MAX_ENTRIES;
        return int'(capacity_reg);
    endfunction

    function automatic cache_rsp_t cache_access(lkv_cmd_t op, logic [15:0] k, logic [15:0] v);
        cache_rsp_t r;
        int         found;
        int         victim;
        int         free_slot;
        int         rank;
        r     = '0;
        found = -1;
        for (int i = 0; i < LKV_MAX_ENTRIES; i++)
            if (found < 0 && line_valid[i] && line_key[i] == k)
                found = i;

        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (op == CMD_GET)
                r.read_value = line_value[found];
            else
                line_value[found] = v;
            // entries more recent than the hit one age by one
            rank = line_age[found];
            for (int i = 0; i < LKV_MAX_ENTRIES; i++)
                if (line_valid[i] && line_age[i] < rank)
                    line_age[i]++;
            line_age[found] = 0;
            return r;
        end

        if (op == CMD_GET)
            return r;

        if (fill_count >= usable_entries())
        begin
            victim = -1;
            for (int i = 0; i < LKV_MAX_ENTRIES; i++)
                if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
                    victim = i;
            if (victim >= 0)
            begin
                r.evicted     = 1'b1;
                r.evicted_key = line_key[victim];
                line_valid[victim] = 1'b0;
                fill_count--;
            end
        end

        free_slot = -1;
        for (int i = 0; i < LKV_MAX_ENTRIES; i++)
            if (free_slot < 0 && !line_valid[i])
                free_slot = i;
        if (free_slot < 0)
            return r;

        for (int i = 0; i < LKV_MAX_ENTRIES; i++)
            if (line_valid[i])
                line_age[i]++;
        line_key[free_slot]   = k;
        line_value[free_slot] = v;
        line_valid[free_slot] = 1'b1;
        line_age[free_slot]   = 0;
        fill_count++;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        cache_req_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            cmd       <= CMD_GET;
            key       <= '0;
            value     <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_responses.push_back(cache_access(lkv_cmd_t'(cmd), key, value));
            if (!req_valid || req_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_requests.pop_front();
                    req_valid <= 1'b1;
                    cmd       <= nxt.op;
                    key       <= nxt.key;
                    value     <= nxt.value;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        cache_rsp_t exp_rsp;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_responses.size() == 0)
                    report_mismatch("response with no request outstanding");
                else
                begin
                    exp_rsp = expected_responses.pop_front();
                    if (hit !== exp_rsp.hit)
                        report_mismatch($sformatf("hit %0b, expected %0b", hit, exp_rsp.hit));
                    if (read_value !== exp_rsp.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  read_value, exp_rsp.read_value));
                    if (evicted !== exp_rsp.evicted)
                        report_mismatch($sformatf("evicted %0b, expected %0b",
                                                  evicted, exp_rsp.evicted));
                    if (evicted_key !== exp_rsp.evicted_key)
                        report_mismatch($sformatf("evicted_key %h, expected %h",
                                                  evicted_key, exp_rsp.evicted_key));
                end
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(lkv_cmd_t op, logic [15:0] k, logic [15:0] v);
        cache_req_t r;
        r.op    = op;
        r.key   = k;
        r.value = v;
        pending_requests.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
            @(negedge clk);
        // let the two pipeline stages drain
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [4:0] cap);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        capacity_reg  = cap;
        clear_store();
        @(negedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 74; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 74; end
            default: begin idle_pct = 38; stall_pct = 38; end
        endcase
    endtask

    task automatic random_traffic(int count);
        logic [15:0] key_pool[LKV_MAX_ENTRIES + 6];
        int          pool_size;
        logic [15:0] k;
        pool_size = usable_entries() + 6;
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = 16'($urandom);
        for (int n = 0; n < count; n++)
        begin
            // mostly recycled keys so hits, updates and evictions happen often
            if ($urandom_range(99) < 75)
                k = key_pool[$urandom_range(pool_size - 1)];
            else
                k = 16'($urandom);
            send($urandom_range(1) ? CMD_PUT : CMD_GET, k, 16'($urandom));
        end
    endtask

    initial
    begin
        logic [4:0] phase_caps[RANDOM_PHASES];
        phase_caps   = '{5'd1, 5'd0, 5'd3, 5'd16, 5'd31, 5'd17, 5'd8, 5'd0};
        phase_caps[RANDOM_PHASES - 1] = 5'($urandom_range(31));
        capacity_reg = LKV_CAP_RESET;
        clear_store();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset capacity, extremes of key and value
        set_idling(3);
        send(CMD_GET, 16'h1234, 16'h0000);
        send(CMD_PUT, 16'h0000, 16'hFFFF);
        send(CMD_PUT, 16'hFFFF, 16'h0000);
        send(CMD_GET, 16'h0000, 16'h0000);
        send(CMD_GET, 16'hFFFF, 16'hFFFF);
        send(CMD_PUT, 16'h0000, 16'h5A5A);
        send(CMD_GET, 16'h0000, 16'h0000);
        send(CMD_GET, 16'hABCD, 16'h0000);

        // directed: two entries, LRU order and eviction of extreme keys
        set_capacity(5'd2);
        send(CMD_GET, 16'h0000, 16'h0000);
        send(CMD_PUT, 16'h0000, 16'h1111);
        send(CMD_PUT, 16'hFFFF, 16'h2222);
        send(CMD_GET, 16'h0000, 16'h0000);
        send(CMD_PUT, 16'h8000, 16'h3333);
        send(CMD_PUT, 16'h7FFF, 16'h4444);
        send(CMD_GET, 16'hFFFF, 16'h0000);
        send(CMD_PUT, 16'h8000, 16'hA5A5);
        send(CMD_PUT, 16'h0001, 16'h5555);
        send(CMD_GET, 16'h8000, 16'h0000);

        // rewriting the same capacity still empties the store
        set_capacity(5'd2);
        send(CMD_GET, 16'h8000, 16'h0000);
        send(CMD_PUT, 16'h0001, 16'hFFFF);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            set_idling(p);
            random_traffic(PHASE_ITEMS);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
hdl/lkv_pkg.sv
hdl/lkv_in_reg.sv
hdl/lkv_store.sv
hdl/lkv_out_reg.sv
hdl/lru_key_value_cache_top.sv
verif/lru_key_value_cache_top_test.sv
